/* design/assert_macros.svh */
// Shared assertion macros; each expects clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`define ASSERT_NEXT(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

/* design/apfr_pkg.sv */
package apfr_pkg;

	localparam int PIXEL_BITS         = 12;
	localparam int CORDIC_STAGES      = 24;
	localparam int COEF_FRACTION_BITS = 24;

	localparam int COEF_W     = 32;
	localparam int BIAS_W     = 15;
	localparam int ANGLE_W    = 16;
	localparam int Z_W        = 32;
	localparam int ATAN_IDX_W = 5;
	localparam int ATAN_W     = 30;
	localparam int PROD_W     = COEF_W + PIXEL_BITS + 1;
	localparam int CORDIC_W   = PROD_W + 3;
	localparam int OUT_Q      = 46;
	localparam int SCALE_W    = 30;
	localparam int MUL_W      = Z_W + SCALE_W;
	localparam int SUM_W      = MUL_W + 1;

	localparam logic signed [SCALE_W-1:0] CENTIDEG_PER_RAD_Q16 = 30'sd375493621;

	localparam logic [ATAN_W-1:0] ATAN_Q30 [2**ATAN_IDX_W] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
		30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
		30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
		30'd262143,    30'd131071,    30'd65535,     30'd32767,
		30'd16383,     30'd8191,      30'd4095,      30'd2047,
		30'd1023,      30'd511,       30'd255,       30'd127,
		30'd63,        30'd31,        30'd15,        30'd8,
		30'd4,         30'd2,         30'd1,         30'd0
	};

	localparam logic [7:0] FRAME_HEAD = 8'hAA;
	localparam logic [7:0] FRAME_TAIL = 8'hDD;
	localparam logic [7:0] FRAME_PAD  = 8'h00;

	localparam int SLOT_W = 3;
	localparam logic [SLOT_W-1:0] SLOT_HEAD     = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_YAW_HI   = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_YAW_LO   = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_PITCH_HI = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_PITCH_LO = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_PAD      = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_TAIL     = 3'd6;

	localparam int GAP_W = 3;
	localparam logic [GAP_W-1:0] GAP_RELOAD = 3'd6;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;
	localparam logic [REG_IDX_W-1:0] REG_YAW_GAIN_U   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_YAW_GAIN_V   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_YAW_OFFSET   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PITCH_GAIN_U = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PITCH_GAIN_V = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PITCH_OFFSET = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_PITCH_BIAS   = 3'd6;

	localparam logic signed [BIAS_W-1:0] BIAS_RESET = 15'sd300;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel_u;
		logic [PIXEL_BITS-1:0] pixel_v;
	} pixel_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frame_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] yaw_gain_u;
		logic signed [COEF_W-1:0] yaw_gain_v;
		logic signed [COEF_W-1:0] yaw_offset;
		logic signed [COEF_W-1:0] pitch_gain_u;
		logic signed [COEF_W-1:0] pitch_gain_v;
		logic signed [COEF_W-1:0] pitch_offset_term;
		logic signed [BIAS_W-1:0] pitch_bias_centideg;
	} cfg_t;

	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [Z_W-1:0]      z;
	} cordic_vec_t;

	typedef struct packed {
		logic        vld;
		cordic_vec_t yaw;
		cordic_vec_t pitch;
	} cordic_cell_t;

	typedef struct packed {
		logic               vld;
		logic [ANGLE_W-1:0] yaw;
		logic [ANGLE_W-1:0] pitch;
	} angle_t;

endpackage

/* design/apfr_regs.sv */
module apfr_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [apfr_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [apfr_pkg::APB_DATA_W-1:0] pwdata,
	output logic [apfr_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output apfr_pkg::cfg_t                  cfg
);

	apfr_pkg::cfg_t                     cfg_q;
	logic [apfr_pkg::REG_IDX_W-1:0]     idx;
	logic                               wr_en;

	assign idx    = paddr[apfr_pkg::APB_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q                     <= '0;
			cfg_q.pitch_bias_centideg <= apfr_pkg::BIAS_RESET;
		end else if (wr_en) begin
			unique case (idx)
				apfr_pkg::REG_YAW_GAIN_U:   cfg_q.yaw_gain_u        <= pwdata;
				apfr_pkg::REG_YAW_GAIN_V:   cfg_q.yaw_gain_v        <= pwdata;
				apfr_pkg::REG_YAW_OFFSET:   cfg_q.yaw_offset        <= pwdata;
				apfr_pkg::REG_PITCH_GAIN_U: cfg_q.pitch_gain_u      <= pwdata;
				apfr_pkg::REG_PITCH_GAIN_V: cfg_q.pitch_gain_v      <= pwdata;
				apfr_pkg::REG_PITCH_OFFSET: cfg_q.pitch_offset_term <= pwdata;
				apfr_pkg::REG_PITCH_BIAS: begin
					cfg_q.pitch_bias_centideg <= pwdata[apfr_pkg::BIAS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			apfr_pkg::REG_YAW_GAIN_U:   prdata = cfg_q.yaw_gain_u;
			apfr_pkg::REG_YAW_GAIN_V:   prdata = cfg_q.yaw_gain_v;
			apfr_pkg::REG_YAW_OFFSET:   prdata = cfg_q.yaw_offset;
			apfr_pkg::REG_PITCH_GAIN_U: prdata = cfg_q.pitch_gain_u;
			apfr_pkg::REG_PITCH_GAIN_V: prdata = cfg_q.pitch_gain_v;
			apfr_pkg::REG_PITCH_OFFSET: prdata = cfg_q.pitch_offset_term;
			apfr_pkg::REG_PITCH_BIAS: begin
				prdata = {{(apfr_pkg::APB_DATA_W-apfr_pkg::BIAS_W){1'b0}},
					cfg_q.pitch_bias_centideg};
			end
			default: prdata = '0;
		endcase
	end

endmodule

/* design/apfr_cordic_cell.sv */
module apfr_cordic_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [apfr_pkg::ATAN_IDX_W-1:0] stage,
	input  apfr_pkg::cordic_cell_t          cell_in,
	output apfr_pkg::cordic_cell_t          cell_out
);

	logic                  vld_q;
	apfr_pkg::cordic_vec_t yaw_q;
	apfr_pkg::cordic_vec_t pitch_q;

	function automatic apfr_pkg::cordic_vec_t rotate(
		input apfr_pkg::cordic_vec_t v,
		input logic [apfr_pkg::ATAN_IDX_W-1:0] s
	);
		logic signed [apfr_pkg::CORDIC_W-1:0] xs;
		logic signed [apfr_pkg::CORDIC_W-1:0] ys;
		logic signed [apfr_pkg::Z_W-1:0]      step;
		apfr_pkg::cordic_vec_t                r;
		xs   = $signed(v.x) >>> s;
		ys   = $signed(v.y) >>> s;
		step = $signed({{(apfr_pkg::Z_W-apfr_pkg::ATAN_W){1'b0}}, apfr_pkg::ATAN_Q30[s]});
		if (!v.y[apfr_pkg::CORDIC_W-1]) begin
			r.x = v.x + ys;
			r.y = v.y - xs;
			r.z = v.z + step;
		end else begin
			r.x = v.x - ys;
			r.y = v.y + xs;
			r.z = v.z - step;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= cell_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		yaw_q   <= rotate(cell_in.yaw, stage);
		pitch_q <= rotate(cell_in.pitch, stage);
	end

	assign cell_out.vld   = vld_q;
	assign cell_out.yaw   = yaw_q;
	assign cell_out.pitch = pitch_q;

endmodule

/* design/apfr_scale.sv */
module apfr_scale (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  apfr_pkg::cordic_cell_t               cordic,
	input  logic signed [apfr_pkg::BIAS_W-1:0]   bias,
	output apfr_pkg::angle_t                     angle
);

	logic                                vld_s1;
	logic                                vld_s2;
	logic                                vld_s3;
	logic signed [apfr_pkg::MUL_W-1:0]   yaw_m_s1;
	logic signed [apfr_pkg::MUL_W-1:0]   pitch_m_s1;
	logic signed [apfr_pkg::SUM_W-1:0]   yaw_a_s2;
	logic signed [apfr_pkg::SUM_W-1:0]   pitch_a_s2;
	logic signed [apfr_pkg::SUM_W-1:0]   yaw_r;
	logic signed [apfr_pkg::SUM_W-1:0]   pitch_r;
	logic [apfr_pkg::ANGLE_W-1:0]        yaw_s3;
	logic [apfr_pkg::ANGLE_W-1:0]        pitch_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cordic.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// bias toward zero for negative sums so the shift truncates instead of floors
	assign yaw_r   = yaw_a_s2 + apfr_pkg::SUM_W'(
		$signed({1'b0, {apfr_pkg::OUT_Q{yaw_a_s2[apfr_pkg::SUM_W-1]}}}));
	assign pitch_r = pitch_a_s2 + apfr_pkg::SUM_W'(
		$signed({1'b0, {apfr_pkg::OUT_Q{pitch_a_s2[apfr_pkg::SUM_W-1]}}}));

	always_ff @(posedge clk) begin
		yaw_m_s1   <= apfr_pkg::MUL_W'($signed(cordic.yaw.z)) *
			apfr_pkg::MUL_W'(apfr_pkg::CENTIDEG_PER_RAD_Q16);
		pitch_m_s1 <= apfr_pkg::MUL_W'($signed(cordic.pitch.z)) *
			apfr_pkg::MUL_W'(apfr_pkg::CENTIDEG_PER_RAD_Q16);
		yaw_a_s2   <= apfr_pkg::SUM_W'(yaw_m_s1);
		pitch_a_s2 <= apfr_pkg::SUM_W'(pitch_m_s1) +
			apfr_pkg::SUM_W'($signed({bias, {apfr_pkg::OUT_Q{1'b0}}}));
		yaw_s3     <= yaw_r[apfr_pkg::OUT_Q+apfr_pkg::ANGLE_W-1:apfr_pkg::OUT_Q];
		pitch_s3   <= pitch_r[apfr_pkg::OUT_Q+apfr_pkg::ANGLE_W-1:apfr_pkg::OUT_Q];
	end

	assign angle.vld   = vld_s3;
	assign angle.yaw   = yaw_s3;
	assign angle.pitch = pitch_s3;

endmodule

/* design/apfr_framer.sv */
`include "assert_macros.svh"

module apfr_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  apfr_pkg::angle_t  angle,
	output logic              strobe,
	output apfr_pkg::frame_t  frame
);

	logic                             load;
	logic                             active_q;
	logic [apfr_pkg::SLOT_W-1:0]      slot_q;
	logic [apfr_pkg::ANGLE_W-1:0]     yaw_q;
	logic [apfr_pkg::ANGLE_W-1:0]     pitch_q;
	logic [7:0]                       tx_byte;

	// drop results whose angles are both zero
	assign load = angle.vld && (angle.yaw != '0 || angle.pitch != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			slot_q   <= apfr_pkg::SLOT_HEAD;
		end else if (load) begin
			active_q <= 1'b1;
			slot_q   <= apfr_pkg::SLOT_HEAD;
		end else if (active_q) begin
			if (slot_q == apfr_pkg::SLOT_TAIL) begin
				active_q <= 1'b0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			yaw_q   <= angle.yaw;
			pitch_q <= angle.pitch;
		end
	end

	always_comb begin
		unique case (slot_q)
			apfr_pkg::SLOT_HEAD:     tx_byte = apfr_pkg::FRAME_HEAD;
			apfr_pkg::SLOT_YAW_HI:   tx_byte = yaw_q[15:8];
			apfr_pkg::SLOT_YAW_LO:   tx_byte = yaw_q[7:0];
			apfr_pkg::SLOT_PITCH_HI: tx_byte = pitch_q[15:8];
			apfr_pkg::SLOT_PITCH_LO: tx_byte = pitch_q[7:0];
			apfr_pkg::SLOT_PAD:      tx_byte = apfr_pkg::FRAME_PAD;
			apfr_pkg::SLOT_TAIL:     tx_byte = apfr_pkg::FRAME_TAIL;
			default:                 tx_byte = apfr_pkg::FRAME_PAD;
		endcase
	end

	assign frame.frame_byte = tx_byte;
	assign frame.last_byte  = (slot_q == apfr_pkg::SLOT_TAIL);
	assign strobe           = active_q;

	`ASSERT_IMPLIES(a_no_overrun, load, !active_q || slot_q == apfr_pkg::SLOT_TAIL, "frame overrun")

endmodule

/* design/pixel_to_aim_angle_framer_top.sv */
// Pixel to aim angle framer.
// Input: one pixel (pixel_u, pixel_v) is transferred at a clock edge with start high
// and busy low. Output: each accepted pixel yields a seven-byte frame
// (0xAA, yaw hi, yaw lo, pitch hi, pitch lo, 0x00, 0xDD), one byte per cycle on
// frame with strobe high; last_byte marks the trailer. A pixel whose yaw and pitch
// both come out zero yields no frame.
// Path: an accepted pixel passes the affine stage, the CORDIC cell row and the scaling
// stages; the framer then loads the result and sends the header byte first.
// Spacing: after each transfer busy stays high while a gap counter counts down to zero,
// so frames do not overlap; a new pixel enters before earlier ones leave. Up to five pixels
// are in flight in the affine stage, the CORDIC cell row and the scaling stages at once.
// Configuration: APB writes to the coefficient registers at 4*index; write only while
// no pixel is in flight. pready is always high.
// Reset: arst_n clears the pipeline and the framer; coefficients reset to zero and
// the pitch bias to 300 centidegrees.
// The receiver cannot stall: each byte is on the ports for exactly one cycle.
`include "assert_macros.svh"

module pixel_to_aim_angle_framer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  apfr_pkg::pixel_t                pixel,
	output logic                            strobe,
	output apfr_pkg::frame_t                frame,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [apfr_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [apfr_pkg::APB_DATA_W-1:0] pwdata,
	output logic [apfr_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	apfr_pkg::cfg_t                       cfg;
	logic                                 accept;
	logic [apfr_pkg::GAP_W-1:0]           gap_q;
	logic                                 vld_s1;
	logic                                 vld_s2;
	logic signed [apfr_pkg::PROD_W-1:0]   yu_s1;
	logic signed [apfr_pkg::PROD_W-1:0]   yv_s1;
	logic signed [apfr_pkg::PROD_W-1:0]   pu_s1;
	logic signed [apfr_pkg::PROD_W-1:0]   pv_s1;
	apfr_pkg::cordic_vec_t                yaw_s2;
	apfr_pkg::cordic_vec_t                pitch_s2;
	apfr_pkg::cordic_cell_t               link [apfr_pkg::CORDIC_STAGES+1];
	apfr_pkg::angle_t                     angle;
	logic signed [apfr_pkg::CORDIC_W-1:0] x_init;

	apfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign accept = start && !busy;
	assign busy   = (gap_q != '0);
	assign x_init = {{(apfr_pkg::CORDIC_W-1-apfr_pkg::COEF_FRACTION_BITS){1'b0}}, 1'b1,
		{apfr_pkg::COEF_FRACTION_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			if (accept) begin
				gap_q <= apfr_pkg::GAP_RELOAD;
			end else if (gap_q != '0) begin
				gap_q <= gap_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		yu_s1      <= apfr_pkg::PROD_W'($signed(cfg.yaw_gain_u)) *
			apfr_pkg::PROD_W'($signed({1'b0, pixel.pixel_u}));
		yv_s1      <= apfr_pkg::PROD_W'($signed(cfg.yaw_gain_v)) *
			apfr_pkg::PROD_W'($signed({1'b0, pixel.pixel_v}));
		pu_s1      <= apfr_pkg::PROD_W'($signed(cfg.pitch_gain_u)) *
			apfr_pkg::PROD_W'($signed({1'b0, pixel.pixel_u}));
		pv_s1      <= apfr_pkg::PROD_W'($signed(cfg.pitch_gain_v)) *
			apfr_pkg::PROD_W'($signed({1'b0, pixel.pixel_v}));
		yaw_s2.x   <= x_init;
		yaw_s2.y   <= apfr_pkg::CORDIC_W'(yu_s1) + apfr_pkg::CORDIC_W'(yv_s1) +
			apfr_pkg::CORDIC_W'($signed(cfg.yaw_offset));
		yaw_s2.z   <= '0;
		pitch_s2.x <= x_init;
		pitch_s2.y <= -(apfr_pkg::CORDIC_W'(pu_s1) + apfr_pkg::CORDIC_W'(pv_s1) +
			apfr_pkg::CORDIC_W'($signed(cfg.pitch_offset_term)));
		pitch_s2.z <= '0;
	end

	assign link[0].vld   = vld_s2;
	assign link[0].yaw   = yaw_s2;
	assign link[0].pitch = pitch_s2;

	for (genvar g = 0; g < apfr_pkg::CORDIC_STAGES; g++) begin : g_cell
		localparam int StageNum = g;
		apfr_cordic_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.stage    (StageNum[apfr_pkg::ATAN_IDX_W-1:0]),
			.cell_in  (link[g]),
			.cell_out (link[g+1])
		);
	end

	apfr_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.cordic (link[apfr_pkg::CORDIC_STAGES]),
		.bias   (cfg.pitch_bias_centideg),
		.angle  (angle)
	);

	apfr_framer u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.angle  (angle),
		.strobe (strobe),
		.frame  (frame)
	);

	`ASSERT_IMPLIES(a_spacing, vld_s1, busy, "pixel accepted without spacing")
	`ASSERT_NEXT(a_frame_start, strobe && frame.last_byte, !strobe || frame.frame_byte == apfr_pkg::FRAME_HEAD, "frame does not start with header")
	`ASSERT_IMPLIES(a_busy_quiet, busy && !vld_s1, gap_q != apfr_pkg::GAP_RELOAD, "gap reload without transfer")

endmodule
